FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker in meg_chk.sv
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define MEG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MEG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/meg_pkg.sv
// package for the multitouch event generator
// types, event codes and sizes used by all files but the macro header; no dependencies
package meg_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MEM_W = 48;

  // command kinds
  localparam logic [2:0] K_DOWN   = 3'd0;
  localparam logic [2:0] K_MOVE   = 3'd1;
  localparam logic [2:0] K_UP     = 3'd2;
  localparam logic [2:0] K_COMMIT = 3'd3;
  localparam logic [2:0] K_RESET  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] R_SLOTTED = 3'd0;
  localparam logic [2:0] R_CID     = 3'd1;
  localparam logic [2:0] R_BTN     = 3'd2;
  localparam logic [2:0] R_MAJOR   = 3'd3;
  localparam logic [2:0] R_WIDTH   = 3'd4;
  localparam logic [2:0] R_PRESS   = 3'd5;
  localparam logic [2:0] R_COUNT   = 3'd6;

  // event types
  localparam logic [1:0] ET_SYN = 2'd0;
  localparam logic [1:0] ET_KEY = 2'd1;
  localparam logic [1:0] ET_ABS = 2'd2;

  // event codes
  localparam logic [3:0] EC_SLOT     = 4'd0;
  localparam logic [3:0] EC_TRK      = 4'd1;
  localparam logic [3:0] EC_MAJOR    = 4'd2;
  localparam logic [3:0] EC_WIDTH    = 4'd3;
  localparam logic [3:0] EC_PRESS    = 4'd4;
  localparam logic [3:0] EC_X        = 4'd5;
  localparam logic [3:0] EC_Y        = 4'd6;
  localparam logic [3:0] EC_BTN      = 4'd7;
  localparam logic [3:0] EC_REPORT   = 4'd8;
  localparam logic [3:0] EC_MTREPORT = 4'd9;

  localparam logic [31:0] VAL_MAJOR   = 32'h0000_0006;
  localparam logic [31:0] VAL_WIDTH   = 32'h0000_0004;
  localparam logic [31:0] VAL_RELEASE = 32'hFFFF_FFFF;
  localparam logic [30:0] TRK_TOP     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  etype;
    logic [3:0]  ecode;
    logic [31:0] evalue;
  } ev_t;

endpackage

FILE: hw/rtl/meg_out.sv
// output stage: holds one event back so the final event of a command gets last
// depends on meg_pkg
module meg_out (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gen_valid_i,
  input  meg_pkg::ev_t gen_ev_i,
  input  logic        flush_i,
  output logic        out_valid_o,
  output logic [1:0]  event_type_o,
  output logic [3:0]  event_code_o,
  output logic signed [31:0] event_value_o,
  output logic        last_o
);

  logic         pend_v_q, pend_v_d;
  meg_pkg::ev_t pend_q;
  logic         out_v_q, out_v_d, last_q, last_d;
  meg_pkg::ev_t out_q;

  // release the held event when a newer one arrives or at the end of a command
  always_comb begin
    pend_v_d = pend_v_q;
    out_v_d  = 1'b0;
    last_d   = 1'b0;
    if (gen_valid_i) begin
      out_v_d  = pend_v_q;
      pend_v_d = 1'b1;
    end else if (flush_i) begin
      out_v_d  = pend_v_q;
      last_d   = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (gen_valid_i) begin
      pend_q <= gen_ev_i;
    end
    out_q  <= pend_q;
    last_q <= last_d;
  end

  assign out_valid_o   = out_v_q;
  assign event_type_o  = out_q.etype;
  assign event_code_o  = out_q.ecode;
  assign event_value_o = out_q.evalue;
  assign last_o        = last_q & out_v_q;

endmodule

FILE: hw/rtl/multitouch_event_generator.sv
// multitouch event generator top level: command sequencer and contact memory
// depends on meg_pkg and meg_out
//
// A command is taken when start_i is high and busy_o low. Events leave one per
// cycle at most on out_valid_o, registered in meg_out behind the sequencer, since
// a one-event hold stage keeps each event until the next one or the end of the
// command and so marks the final event with last_o; the receiver cannot stall.
// Anonymous down, move and up without a flush stay idle and emit nothing.
// Slotted move, down and up run an 8-step event template, after a sync report
// when a down first flushes the active contacts. Anonymous commit reads each
// non-idle contact from the coordinate memory, then runs an 8-step template
// for it; idle contacts are skipped.
module multitouch_event_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  contact_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] press_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  output logic        out_valid_o,
  output logic [1:0]  event_type_o,
  output logic [3:0]  event_code_o,
  output logic signed [31:0] event_value_o,
  output logic        last_o
);

  localparam int MAXC = meg_pkg::SLOT_COUNT;
  localparam int IW   = meg_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SYNC = 3'd1;
  localparam logic [2:0] S_SLOT = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_WEV  = 3'd4;
  localparam logic [2:0] S_WEND = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // configuration
  logic       slotted_q, cid_q, btn_q, major_q, width_q, press_en_q;
  logic [2:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slotted_q  <= 1'b1;
      cid_q      <= 1'b1;
      btn_q      <= 1'b1;
      major_q    <= 1'b0;
      width_q    <= 1'b0;
      press_en_q <= 1'b1;
      count_q    <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        meg_pkg::R_SLOTTED: slotted_q  <= cfg_data_i[0];
        meg_pkg::R_CID:     cid_q      <= cfg_data_i[0];
        meg_pkg::R_BTN:     btn_q      <= cfg_data_i[0];
        meg_pkg::R_MAJOR:   major_q    <= cfg_data_i[0];
        meg_pkg::R_WIDTH:   width_q    <= cfg_data_i[0];
        meg_pkg::R_PRESS:   press_en_q <= cfg_data_i[0];
        meg_pkg::R_COUNT:   count_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]    state_q, state_d;
  logic [2:0]    kind_q, kind_d;
  logic [IW-1:0] cidx_q, cidx_d;
  logic [15:0]   x_q, y_q, p_q;
  logic [2:0]    step_q, step_d;
  logic [3:0]    walk_q, walk_d;
  logic          any_q, any_d;
  logic [1:0]    phase_q [MAXC];
  logic [1:0]    phase_d [MAXC];
  logic [30:0]   cnt_q, cnt_d;

  // contact coordinate memory {pressure, y, x}
  logic [meg_pkg::MEM_W-1:0] mem [MAXC];
  logic [meg_pkg::MEM_W-1:0] rd_q, wdata;
  logic [MAXC-1:0] mem_v_q;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;

  logic [3:0]    n;
  logic          c_ok, c_act, any_act, accept;
  logic [IW-1:0] ci, wk;
  logic [1:0]    wph;
  logic          gen_v, flush;
  meg_pkg::ev_t  gen;

  assign n = ({1'b0, count_q} > 4'(MAXC)) ? 4'(MAXC) : {1'b0, count_q};
  assign ci = contact_i[IW-1:0];
  assign c_ok = contact_i < n;
  assign c_act = phase_q[ci] != 2'd0;
  assign accept = start_i && (state_q == S_IDLE);
  assign wk = walk_q[IW-1:0];
  assign wph = phase_q[wk];

  // any active contact below the count
  always_comb begin
    any_act = 1'b0;
    for (int k = 0; k < MAXC; k++) begin
      if ((4'(k) < n) && (phase_q[k] != 2'd0)) any_act = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cidx_d  = cidx_q;
    step_d  = step_q;
    walk_d  = walk_q;
    any_d   = any_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    we      = 1'b0;
    waddr   = ci;
    wdata   = {press_i, pos_y_i, pos_x_i};
    re      = 1'b0;
    raddr   = wk;
    gen_v   = 1'b0;
    gen     = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_SLOT, evalue: 32'd0};
    flush   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = kind_i;
          cidx_d = ci;
          step_d = 3'd0;
          walk_d = 4'd0;
          any_d  = 1'b0;
          case (kind_i)
            meg_pkg::K_DOWN: begin
              if (c_ok) begin
                if (slotted_q) begin
                  if (c_act) begin
                    for (int k = 0; k < MAXC; k++)
                      if (4'(k) < n) phase_d[k] = 2'd0;
                    state_d = S_SYNC;
                  end else begin
                    state_d = S_SLOT;
                  end
                  phase_d[ci] = 2'd1;
                  cnt_d = (cnt_q < meg_pkg::TRK_TOP) ? cnt_q + 31'd1 : 31'd0;
                end else if (c_act) begin
                  for (int k = 0; k < MAXC; k++)
                    if ((4'(k) < n) && (phase_q[k] == 2'd1 || phase_q[k] == 2'd2))
                      phase_d[k] = 2'd3;
                  state_d = S_WRD;
                end else begin
                  phase_d[ci] = 2'd1;
                  we = 1'b1;
                end
              end
            end
            meg_pkg::K_MOVE: begin
              if (c_ok && c_act) begin
                if (slotted_q) begin
                  state_d = S_SLOT;
                end else begin
                  phase_d[ci] = 2'd2;
                  we = 1'b1;
                end
              end
            end
            meg_pkg::K_UP: begin
              if (c_ok && c_act) begin
                if (slotted_q) begin
                  phase_d[ci] = 2'd0;
                  state_d = S_SLOT;
                end else begin
                  phase_d[ci] = 2'd3;
                end
              end
            end
            meg_pkg::K_COMMIT: begin
              state_d = slotted_q ? S_SYNC : S_WRD;
            end
            meg_pkg::K_RESET: begin
              if (slotted_q) begin
                if (any_act) begin
                  for (int k = 0; k < MAXC; k++)
                    if (4'(k) < n) phase_d[k] = 2'd0;
                  state_d = S_SYNC;
                end
              end else begin
                for (int k = 0; k < MAXC; k++)
                  if ((4'(k) < n) && (phase_q[k] == 2'd1 || phase_q[k] == 2'd2))
                    phase_d[k] = 2'd3;
                state_d = S_WRD;
              end
            end
            default: ;
          endcase
        end
      end
      // sync report
      S_SYNC: begin
        gen_v = 1'b1;
        gen = '{etype: meg_pkg::ET_SYN, ecode: meg_pkg::EC_REPORT, evalue: 32'd0};
        state_d = (kind_q == meg_pkg::K_DOWN) ? S_SLOT : S_FIN;
      end
      // slotted down, move and up template
      S_SLOT: begin
        case (step_q)
          3'd0: begin
            gen_v = 1'b1;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_SLOT,
                    evalue: 32'(cidx_q)};
          end
          3'd1: begin
            gen_v = kind_q != meg_pkg::K_MOVE;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_TRK,
                    evalue: (kind_q == meg_pkg::K_UP) ? meg_pkg::VAL_RELEASE
                                                      : {1'b0, cnt_q}};
          end
          3'd2: begin
            gen_v = btn_q && ((kind_q == meg_pkg::K_DOWN) ||
                              (kind_q == meg_pkg::K_UP && !any_act));
            gen = '{etype: meg_pkg::ET_KEY, ecode: meg_pkg::EC_BTN,
                    evalue: (kind_q == meg_pkg::K_DOWN) ? 32'd1 : 32'd0};
          end
          3'd3: begin
            gen_v = major_q && kind_q != meg_pkg::K_UP;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_MAJOR,
                    evalue: meg_pkg::VAL_MAJOR};
          end
          3'd4: begin
            gen_v = width_q && kind_q != meg_pkg::K_UP;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_WIDTH,
                    evalue: meg_pkg::VAL_WIDTH};
          end
          3'd5: begin
            gen_v = press_en_q && kind_q != meg_pkg::K_UP;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_PRESS,
                    evalue: {16'd0, p_q}};
          end
          3'd6: begin
            gen_v = kind_q != meg_pkg::K_UP;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_X, evalue: {16'd0, x_q}};
          end
          default: begin
            gen_v = kind_q != meg_pkg::K_UP;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_Y, evalue: {16'd0, y_q}};
          end
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) state_d = S_FIN;
      end
      // anonymous walk: pick the next non-idle contact and read its entry
      S_WRD: begin
        if (walk_q >= n) begin
          state_d = S_WEND;
        end else if (wph == 2'd0) begin
          walk_d = walk_q + 4'd1;
        end else begin
          any_d   = 1'b1;
          re      = 1'b1;
          step_d  = 3'd0;
          state_d = S_WEV;
        end
      end
      // anonymous per-contact template, entry data in rd_q
      S_WEV: begin
        case (step_q)
          3'd0: begin
            gen_v = cid_q;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_TRK, evalue: 32'(wk)};
          end
          3'd1: begin
            gen_v = btn_q && (wph == 2'd3 || wph == 2'd1);
            gen = '{etype: meg_pkg::ET_KEY, ecode: meg_pkg::EC_BTN,
                    evalue: (wph == 2'd1) ? 32'd1 : 32'd0};
          end
          3'd2: begin
            gen_v = major_q && wph != 2'd3;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_MAJOR,
                    evalue: meg_pkg::VAL_MAJOR};
          end
          3'd3: begin
            gen_v = width_q && wph != 2'd3;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_WIDTH,
                    evalue: meg_pkg::VAL_WIDTH};
          end
          3'd4: begin
            gen_v = press_en_q && wph != 2'd3;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_PRESS,
                    evalue: {16'd0, rd_q[47:32]}};
          end
          3'd5: begin
            gen_v = wph != 2'd3;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_X,
                    evalue: {16'd0, rd_q[15:0]}};
          end
          3'd6: begin
            gen_v = wph != 2'd3;
            gen = '{etype: meg_pkg::ET_ABS, ecode: meg_pkg::EC_Y,
                    evalue: {16'd0, rd_q[31:16]}};
          end
          default: begin
            gen_v = 1'b1;
            gen = '{etype: meg_pkg::ET_SYN, ecode: meg_pkg::EC_MTREPORT, evalue: 32'd0};
            phase_d[wk] = (wph == 2'd3) ? 2'd0 : 2'd2;
            walk_d = walk_q + 4'd1;
            state_d = S_WRD;
          end
        endcase
        step_d = step_q + 3'd1;
      end
      // closing report if any contact was walked, and the deferred anonymous down
      S_WEND: begin
        gen_v = any_q;
        gen = '{etype: meg_pkg::ET_SYN, ecode: meg_pkg::EC_REPORT, evalue: 32'd0};
        if (kind_q == meg_pkg::K_DOWN) begin
          phase_d[cidx_q] = 2'd1;
          we    = 1'b1;
          waddr = cidx_q;
          wdata = {p_q, y_q, x_q};
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        flush   = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= meg_pkg::K_COMMIT;
      cidx_q  <= '0;
      step_q  <= 3'd0;
      walk_q  <= 4'd0;
      any_q   <= 1'b0;
      cnt_q   <= 31'd0;
      for (int k = 0; k < MAXC; k++) phase_q[k] <= 2'd0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cidx_q  <= cidx_d;
      step_q  <= step_d;
      walk_q  <= walk_d;
      any_q   <= any_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      p_q <= press_i;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_v_q <= '0;
    end else if (we) begin
      mem_v_q[waddr] <= 1'b1;
    end
  end

  // memory: writes and reads never overlap, the walk ends before the deferred store
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem_v_q[raddr] ? mem[raddr] : '0;
  end

  assign busy_o = state_q != S_IDLE;

  meg_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gen_valid_i   (gen_v),
    .gen_ev_i      (gen),
    .flush_i       (flush),
    .out_valid_o   (out_valid_o),
    .event_type_o  (event_type_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .last_o        (last_o)
  );

endmodule

FILE: hw/rtl/meg_chk.sv
// port-level checker for the multitouch event generator, with its bind
// depends on meg_pkg and assert_macros.svh
`include "assert_macros.svh"

module meg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        out_valid_o,
  input logic [1:0]  event_type_o,
  input logic signed [31:0] event_value_o,
  input logic        last_o
);

  // last only marks a real item
  `MEG_ASSERT_IMP(a_last_valid, last_o, out_valid_o, "last without item")
  // a command's items end before the next command can produce any
  `MEG_ASSERT_NXT(a_gap, out_valid_o && last_o, !out_valid_o, "item right after last")
  // a newly taken command shows nothing in the following cycle
  `MEG_ASSERT_NXT(a_start_quiet, start_i && !busy_o, !out_valid_o, "item too early")
  // sync reports carry zero
  `MEG_ASSERT_IMP(a_sync_zero, out_valid_o && event_type_o == meg_pkg::ET_SYN,
                  event_value_o == 32'sd0, "sync item with nonzero value")

endmodule

bind multitouch_event_generator meg_chk u_meg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .out_valid_o   (out_valid_o),
  .event_type_o  (event_type_o),
  .event_value_o (event_value_o),
  .last_o        (last_o)
);

FILE: tb/multitouch_event_generator_tb.sv
// testbench for the multitouch event generator: directed and random touch commands
// depends on meg_pkg and multitouch_event_generator; predicts every event in the bench
module multitouch_event_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  contact;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pr;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  etype;
    logic [3:0]  ecode;
    logic [31:0] evalue;
    logic        elast;
  } tev_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] kind_i = '0;
  logic [3:0] contact_i = '0;
  logic [15:0] pos_x_i = '0, pos_y_i = '0, press_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0, cfg_data_i = '0;
  logic out_valid_o;
  logic [1:0] event_type_o;
  logic [3:0] event_code_o;
  logic signed [31:0] event_value_o;
  logic last_o;

  multitouch_event_generator uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state and configuration
  logic       m_slot, m_cid, m_btn, m_major, m_width, m_press;
  logic [2:0] m_count;
  logic [1:0] m_phase [meg_pkg::SLOT_COUNT];
  logic [15:0] m_x [meg_pkg::SLOT_COUNT], m_y [meg_pkg::SLOT_COUNT];
  logic [15:0] m_p [meg_pkg::SLOT_COUNT];
  logic [30:0] m_trk;

  tev_t  want_q[$];
  cmd_t  pend_q[$];
  int    errors = 0;
  int    n_events;
  bit    quiet = 1'b0;
  bit    hold_off = 1'b0;
  bit    taken = 1'b0;

  function automatic int live_count();
    return (m_count > meg_pkg::SLOT_COUNT) ? meg_pkg::SLOT_COUNT : int'(m_count);
  endfunction

  function automatic void push_ev(logic [1:0] t, logic [3:0] c, logic [31:0] v);
    want_q.push_back('{t, c, v, 1'b0});
    n_events++;
  endfunction

  function automatic void push_shape(logic [15:0] p, logic [15:0] x, logic [15:0] y);
    if (m_major) push_ev(meg_pkg::ET_ABS, meg_pkg::EC_MAJOR, meg_pkg::VAL_MAJOR);
    if (m_width) push_ev(meg_pkg::ET_ABS, meg_pkg::EC_WIDTH, meg_pkg::VAL_WIDTH);
    if (m_press) push_ev(meg_pkg::ET_ABS, meg_pkg::EC_PRESS, {16'h0, p});
    push_ev(meg_pkg::ET_ABS, meg_pkg::EC_X, {16'h0, x});
    push_ev(meg_pkg::ET_ABS, meg_pkg::EC_Y, {16'h0, y});
  endfunction

  function automatic void anon_flush();
    bit any;
    any = 0;
    for (int c = 0; c < live_count(); c++) begin
      if (m_phase[c] != 0) begin
        any = 1;
        if (m_cid) push_ev(meg_pkg::ET_ABS, meg_pkg::EC_TRK, c);
        if (m_phase[c] == 3) begin
          if (m_btn) push_ev(meg_pkg::ET_KEY, meg_pkg::EC_BTN, 0);
          push_ev(meg_pkg::ET_SYN, meg_pkg::EC_MTREPORT, 0);
          m_phase[c] = 0;
        end else begin
          if (m_phase[c] == 1 && m_btn) push_ev(meg_pkg::ET_KEY, meg_pkg::EC_BTN, 1);
          push_shape(m_p[c], m_x[c], m_y[c]);
          push_ev(meg_pkg::ET_SYN, meg_pkg::EC_MTREPORT, 0);
          m_phase[c] = 2;
        end
      end
    end
    if (any) push_ev(meg_pkg::ET_SYN, meg_pkg::EC_REPORT, 0);
  endfunction

  function automatic void anon_release_all();
    for (int c = 0; c < live_count(); c++)
      if (m_phase[c] == 1 || m_phase[c] == 2) m_phase[c] = 3;
    anon_flush();
  endfunction

  function automatic void slot_release_all();
    bit any;
    any = 0;
    for (int c = 0; c < live_count(); c++)
      if (m_phase[c] != 0) begin
        m_phase[c] = 0;
        any = 1;
      end
    if (any) push_ev(meg_pkg::ET_SYN, meg_pkg::EC_REPORT, 0);
  endfunction

  // work out the events one command causes
  function automatic void predict_events(cmd_t cm);
    int n, c;
    bit any;
    n = live_count();
    c = cm.contact;
    n_events = 0;
    case (cm.kind)
      meg_pkg::K_DOWN: if (c < n) begin
        if (m_slot) begin
          if (m_phase[c] != 0) slot_release_all();
          m_trk = (m_trk < meg_pkg::TRK_TOP) ? m_trk + 31'd1 : '0;
          push_ev(meg_pkg::ET_ABS, meg_pkg::EC_SLOT, c);
          push_ev(meg_pkg::ET_ABS, meg_pkg::EC_TRK, {1'b0, m_trk});
          if (m_btn) push_ev(meg_pkg::ET_KEY, meg_pkg::EC_BTN, 1);
          m_phase[c] = 1;
          push_shape(cm.pr, cm.px, cm.py);
        end else begin
          if (m_phase[c] != 0) anon_release_all();
          m_phase[c] = 1;
          m_x[c] = cm.px; m_y[c] = cm.py; m_p[c] = cm.pr;
        end
      end
      meg_pkg::K_MOVE: if (c < n && m_phase[c] != 0) begin
        if (m_slot) begin
          push_ev(meg_pkg::ET_ABS, meg_pkg::EC_SLOT, c);
          push_shape(cm.pr, cm.px, cm.py);
        end else begin
          m_phase[c] = 2;
          m_x[c] = cm.px; m_y[c] = cm.py; m_p[c] = cm.pr;
        end
      end
      meg_pkg::K_UP: if (c < n && m_phase[c] != 0) begin
        if (m_slot) begin
          m_phase[c] = 0;
          push_ev(meg_pkg::ET_ABS, meg_pkg::EC_SLOT, c);
          push_ev(meg_pkg::ET_ABS, meg_pkg::EC_TRK, meg_pkg::VAL_RELEASE);
          any = 0;
          for (int k = 0; k < n; k++) if (m_phase[k] != 0) any = 1;
          if (m_btn && !any) push_ev(meg_pkg::ET_KEY, meg_pkg::EC_BTN, 0);
        end else m_phase[c] = 3;
      end
      meg_pkg::K_COMMIT:
        if (m_slot) push_ev(meg_pkg::ET_SYN, meg_pkg::EC_REPORT, 0); else anon_flush();
      meg_pkg::K_RESET: if (m_slot) slot_release_all(); else anon_release_all();
      default: ;
    endcase
    if (n_events > 0) want_q[$].elast = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("error at %0t: %s", $realtime, what);
  endtask

  // driver: holds an item until it is taken, random gaps between items
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !taken) begin
        // hold the item
      end else if (pend_q.size() > 0 && !hold_off && (quiet || $urandom_range(99) >= 15)) begin
        cmd_t cm;
        cm = pend_q.pop_front();
        kind_i <= cm.kind; contact_i <= cm.contact;
        pos_x_i <= cm.px; pos_y_i <= cm.py; press_i <= cm.pr;
        start_i <= 1'b1;
      end else start_i <= 1'b0;
    end
  end

  // predict at the accepting edge
  always @(posedge clk_i) begin
    taken = rst_ni && start_i && !busy_o;
    if (taken) predict_events('{kind_i, contact_i, pos_x_i, pos_y_i, press_i});
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      tev_t w;
      if (want_q.size() == 0) report_mismatch("event with none expected");
      else begin
        w = want_q.pop_front();
        if (event_type_o !== w.etype) report_mismatch($sformatf("type %0d want %0d",
          event_type_o, w.etype));
        if (event_code_o !== w.ecode) report_mismatch($sformatf("code %0d want %0d",
          event_code_o, w.ecode));
        if (event_value_o !== w.evalue) report_mismatch($sformatf("value %0h want %0h",
          event_value_o, w.evalue));
        if (last_o !== w.elast) report_mismatch($sformatf("last %0b want %0b",
          last_o, w.elast));
      end
    end
  end

  function automatic cmd_t rand_cmd(bit noisy);
    cmd_t cm;
    cm.kind = noisy ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    if ($urandom_range(9) == 0) cm.kind = meg_pkg::K_COMMIT;
    cm.contact = noisy ? 4'($urandom_range(15)) : 4'($urandom_range(4));
    cm.px = 16'($urandom); cm.py = 16'($urandom); cm.pr = 16'($urandom);
    case ($urandom_range(7))
      0: cm.px = 16'hFFFF;
      1: cm.py = 16'h0;
      2: cm.pr = 16'hFFFF;
      default: ;
    endcase
    return cm;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      meg_pkg::R_SLOTTED: m_slot = val[0];
      meg_pkg::R_CID:     m_cid = val[0];
      meg_pkg::R_BTN:     m_btn = val[0];
      meg_pkg::R_MAJOR:   m_major = val[0];
      meg_pkg::R_WIDTH:   m_width = val[0];
      meg_pkg::R_PRESS:   m_press = val[0];
      meg_pkg::R_COUNT:   m_count = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until the block has drained everything
  task automatic drain();
    while (pend_q.size() > 0 || start_i || busy_o || want_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_all(logic [6:0] f, logic [2:0] cnt);
    write_reg(meg_pkg::R_SLOTTED, f[0]); write_reg(meg_pkg::R_CID, f[1]);
    write_reg(meg_pkg::R_BTN, f[2]); write_reg(meg_pkg::R_MAJOR, f[3]);
    write_reg(meg_pkg::R_WIDTH, f[4]); write_reg(meg_pkg::R_PRESS, f[5]);
    write_reg(meg_pkg::R_COUNT, cnt);
  endtask

  initial begin
    m_slot = 1; m_cid = 1; m_btn = 1; m_major = 0; m_width = 0; m_press = 1;
    m_count = 4; m_trk = '0;
    for (int c = 0; c < meg_pkg::SLOT_COUNT; c++) begin
      m_phase[c] = 0; m_x[c] = 0; m_y[c] = 0; m_p[c] = 0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // directed: slotted with every capability
    set_all(7'b0111111, 3'd4);
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd0, 16'hFFFF, 16'h0, 16'hFFFF});
    pend_q.push_back('{meg_pkg::K_MOVE, 4'd0, 16'h0, 16'hFFFF, 16'h0});
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd3, 16'h1234, 16'h5678, 16'h9abc});
    pend_q.push_back('{meg_pkg::K_UP, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_COMMIT, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd3, 16'h1, 16'h2, 16'h3}); // down on active contact
    pend_q.push_back('{meg_pkg::K_UP, 4'd3, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_MOVE, 4'd2, 16'h0, 16'h0, 16'h0}); // idle, rejected
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd15, 16'h0, 16'h0, 16'h0}); // out of range
    pend_q.push_back('{3'd5, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{3'd7, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd1, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_RESET, 4'd0, 16'h0, 16'h0, 16'h0});
    drain();
    // anonymous mode, phases carried over
    set_all(7'b0111110, 3'd7);
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd0, 16'hAAAA, 16'h5555, 16'hFFFF});
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd2, 16'h0, 16'hFFFF, 16'h0});
    pend_q.push_back('{meg_pkg::K_COMMIT, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_MOVE, 4'd2, 16'h1, 16'h1, 16'h1});
    pend_q.push_back('{meg_pkg::K_UP, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_COMMIT, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd2, 16'h7, 16'h8, 16'h9}); // down on active contact
    pend_q.push_back('{meg_pkg::K_RESET, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_COMMIT, 4'd0, 16'h0, 16'h0, 16'h0}); // empty commit
    drain();
    set_all(7'b0000000, 3'd0);
    pend_q.push_back('{meg_pkg::K_DOWN, 4'd0, 16'h0, 16'h0, 16'h0});
    pend_q.push_back('{meg_pkg::K_COMMIT, 4'd0, 16'h0, 16'h0, 16'h0});
    drain();
    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      logic [6:0] f;
      f = 7'($urandom);
      if (ph == 0) f = 7'h7F;
      if (ph == 1) f = 7'h00;
      set_all(f, (ph == 2) ? 3'd1 : 3'($urandom_range(7)));
      quiet = (ph == 3);
      for (int i = 0; i < 12; i++) pend_q.push_back(rand_cmd($urandom_range(4) == 0));
      if (ph == 5) begin
        // pause the sender until everything due has come out
        while (pend_q.size() > 8) @(posedge clk_i);
        hold_off = 1'b1;
        while (start_i || busy_o || want_q.size() > 0) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: multitouch_event_generator.f
+incdir+hw/rtl
hw/rtl/meg_pkg.sv
hw/rtl/meg_out.sv
hw/rtl/multitouch_event_generator.sv
hw/rtl/meg_chk.sv
tb/multitouch_event_generator_tb.sv
